### src/tun_pkg.sv
package tun_pkg;

    // three components per vector
    localparam int LANES = 3;

    // edge magnitudes are kept below 2^EDGE_LIM
    localparam int EDGE_LIM = 30;

    // cross product magnitudes are kept below 2^CROSS_LIM
    localparam int CROSS_LIM = 31;

    // fixed pipeline depth of tun_front
    localparam int FRONT_STAGES = 5;

endpackage

### src/tun_front.sv
module tun_front #(
    parameter int CB  = 16,
    parameter int SEW = 17,
    parameter int PW  = 34,
    parameter int MW  = 31,
    parameter int LW  = 64
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CB-1:0] pt [9],
    output logic [2*MW-1:0]      sq [tun_pkg::LANES],
    output logic [LW-1:0]        len2,
    output logic                 neg [tun_pkg::LANES]
);

    localparam int EW  = CB + 1;
    localparam int NW  = PW + 1;
    localparam int SQW = 2 * MW;

    logic signed [EW-1:0]  ed [6];
    logic signed [SEW-1:0] es [6];
    logic signed [SEW-1:0] e_reg [6];
    logic signed [PW-1:0]  p_reg [6];
    logic signed [NW-1:0]  nc [tun_pkg::LANES];
    logic [PW-1:0]         nmag [tun_pkg::LANES];
    logic [MW-1:0]         ms [tun_pkg::LANES];
    logic [MW-1:0]         m_reg [tun_pkg::LANES];
    logic                  ng1_reg [tun_pkg::LANES];
    logic [SQW-1:0]        sq1_reg [tun_pkg::LANES];
    logic                  ng2_reg [tun_pkg::LANES];
    logic [SQW-1:0]        sq2_reg [tun_pkg::LANES];
    logic                  ng3_reg [tun_pkg::LANES];
    logic [LW-1:0]         len_reg;

    // edge vectors: c - b in slots 0..2, a - b in slots 3..5
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ed[i]     = EW'(pt[6+i]) - EW'(pt[3+i]);
            ed[3 + i] = EW'(pt[i]) - EW'(pt[3+i]);
        end
    end

    // common right shift of wide edges, truncating magnitudes
    generate
        if (EW > tun_pkg::EDGE_LIM + 1)
        begin : g_eshr
            localparam int KW = $clog2(EW + 1);
            logic [EW-1:0] emag [6];
            logic [EW-1:0] esh [6];
            logic [EW-1:0] eor;
            logic [KW-1:0] ek;
            always_comb
            begin
                eor = '0;
                for (int i = 0; i < 6; i++)
                begin
                    emag[i] = ed[i][EW-1] ? EW'(-ed[i]) : EW'(ed[i]);
                    eor     = eor | emag[i];
                end
                ek = '0;
                for (int b = tun_pkg::EDGE_LIM; b < EW; b++)
                begin
                    if (eor[b])
                    begin
                        ek = KW'(b - tun_pkg::EDGE_LIM + 1);
                    end
                end
                for (int i = 0; i < 6; i++)
                begin
                    esh[i] = emag[i] >> ek;
                    es[i]  = ed[i][EW-1] ? -SEW'(esh[i]) : SEW'(esh[i]);
                end
            end
        end
        else
        begin : g_enone
            always_comb
            begin
                for (int i = 0; i < 6; i++)
                begin
                    es[i] = SEW'(ed[i]);
                end
            end
        end
    endgenerate

    // stage 1: edges
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= es;
        end
    end

    // stage 2: six partial products of the cross product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= PW'(e_reg[1]) * PW'(e_reg[5]);
            p_reg[1] <= PW'(e_reg[2]) * PW'(e_reg[4]);
            p_reg[2] <= PW'(e_reg[2]) * PW'(e_reg[3]);
            p_reg[3] <= PW'(e_reg[0]) * PW'(e_reg[5]);
            p_reg[4] <= PW'(e_reg[0]) * PW'(e_reg[4]);
            p_reg[5] <= PW'(e_reg[1]) * PW'(e_reg[3]);
        end
    end

    // cross product components as sign and magnitude
    always_comb
    begin
        nc[0] = NW'(p_reg[0]) - NW'(p_reg[1]);
        nc[1] = NW'(p_reg[2]) - NW'(p_reg[3]);
        nc[2] = NW'(p_reg[4]) - NW'(p_reg[5]);
        for (int i = 0; i < tun_pkg::LANES; i++)
        begin
            nmag[i] = nc[i][NW-1] ? PW'(-nc[i]) : PW'(nc[i]);
        end
    end

    // common right shift of a wide cross product
    generate
        if (PW > tun_pkg::CROSS_LIM)
        begin : g_nshr
            localparam int KW = $clog2(PW + 1);
            logic [PW-1:0] nor_v;
            logic [KW-1:0] nk;
            always_comb
            begin
                nor_v = nmag[0] | nmag[1] | nmag[2];
                nk    = '0;
                for (int b = tun_pkg::CROSS_LIM; b < PW; b++)
                begin
                    if (nor_v[b])
                    begin
                        nk = KW'(b - tun_pkg::CROSS_LIM + 1);
                    end
                end
                for (int i = 0; i < tun_pkg::LANES; i++)
                begin
                    ms[i] = MW'(nmag[i] >> nk);
                end
            end
        end
        else
        begin : g_nnone
            always_comb
            begin
                for (int i = 0; i < tun_pkg::LANES; i++)
                begin
                    ms[i] = MW'(nmag[i]);
                end
            end
        end
    endgenerate

    // stages 3..5: magnitudes, squares, squared length
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < tun_pkg::LANES; i++)
            begin
                m_reg[i]   <= ms[i];
                ng1_reg[i] <= nc[i][NW-1];
                sq1_reg[i] <= SQW'(m_reg[i]) * SQW'(m_reg[i]);
                ng2_reg[i] <= ng1_reg[i];
                sq2_reg[i] <= sq1_reg[i];
                ng3_reg[i] <= ng2_reg[i];
            end
            len_reg <= LW'(sq1_reg[0]) + LW'(sq1_reg[1]) + LW'(sq1_reg[2]);
        end
    end

    assign sq   = sq2_reg;
    assign neg  = ng3_reg;
    assign len2 = len_reg;

endmodule

### src/tun_divide.sv
module tun_divide #(
    parameter int SQW = 62,
    parameter int LW  = 64,
    parameter int QB  = 33
) (
    input  logic           clk,
    input  logic           en,
    input  logic [SQW-1:0] num,
    input  logic [LW-1:0]  den,
    output logic [QB-1:0]  quo
);

    // restoring division of num * 2^(QB-1) by den, one quotient bit per stage
    logic [LW-1:0] r_reg [QB];
    logic [LW-1:0] d_reg [QB];
    logic [QB-1:0] q_reg [QB];

    genvar j;
    generate
        for (j = 0; j < QB; j++)
        begin : g_step
            logic [LW:0]   r_in;
            logic [LW-1:0] d_in;
            logic [QB-1:0] q_in;
            logic          ge;
            if (j == 0)
            begin : g_first
                assign r_in = (LW + 1)'(num);
                assign d_in = den;
                assign q_in = '0;
            end
            else
            begin : g_next
                assign r_in = {r_reg[j-1], 1'b0};
                assign d_in = d_reg[j-1];
                assign q_in = q_reg[j-1];
            end
            assign ge = r_in >= (LW + 1)'(d_in);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j] <= ge ? LW'(r_in - (LW + 1)'(d_in)) : LW'(r_in);
                    d_reg[j] <= d_in;
                    q_reg[j] <= {q_in[QB-2:0], ge};
                end
            end
        end
    endgenerate

    assign quo = q_reg[QB-1];

endmodule

### src/tun_isqrt.sv
module tun_isqrt #(
    parameter int QB = 33,
    parameter int TW = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [QB-1:0] rad,
    output logic [TW-1:0] root
);

    localparam int XW = QB + 2;

    // digit-by-digit square root, one root bit per stage, remainder kept
    logic [XW-1:0] rem_reg [TW];
    logic [TW-1:0] t_reg [TW];

    genvar s;
    generate
        for (s = 0; s < TW; s++)
        begin : g_step
            localparam int K = TW - 1 - s;
            logic [XW-1:0] rem_in;
            logic [TW-1:0] t_in;
            logic [XW-1:0] cand;
            logic          ge;
            if (s == 0)
            begin : g_first
                assign rem_in = XW'(rad);
                assign t_in   = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[s-1];
                assign t_in   = t_reg[s-1];
            end
            // (t + 2^K)^2 - t^2
            assign cand = (XW'(t_in) << (K + 1)) + (XW'(1) << (2 * K));
            assign ge   = rem_in >= cand;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= ge ? rem_in - cand : rem_in;
                    t_reg[s]   <= t_in | (TW'(ge) << K);
                end
            end
        end
    endgenerate

    assign root = t_reg[TW-1];

endmodule

### src/triangle_unit_normal_top.sv
// channel  dir  signals                 word
// s_axis   in   tvalid tready tdata     a_x a_y a_z b_x b_y b_z c_x c_y c_z
// m_axis   out  tvalid tready tdata     norm_x norm_y norm_z; tuser = degenerate
//
// One word per clock sustained while m_axis_tready stays high. The pipeline runs
// through tun_front, the bit-per-stage divider and square root, and the output register.
// rst_n clears the valid bits only; datapath registers are not reset.
// The whole pipeline holds while a result waits on m_axis; input is taken
// whenever the output register is empty or being read.
module triangle_unit_normal_top #(
    parameter int COORD_BITS  = 16,
    parameter int NORMAL_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up, zero pad
    input  logic [((9*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // norm_x, norm_y, norm_z from bit 0 up, zero pad
    output logic [((3*NORMAL_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // degenerate
    output logic                                   m_axis_tuser
);

    localparam int CB   = COORD_BITS;
    localparam int NB   = NORMAL_BITS;
    localparam int OW   = ((3 * NB + 7) / 8) * 8;
    localparam int SEW  = (CB > tun_pkg::EDGE_LIM) ? tun_pkg::EDGE_LIM + 1 : CB + 1;
    localparam int PW   = 2 * SEW;
    localparam int MW   = (PW > tun_pkg::CROSS_LIM) ? tun_pkg::CROSS_LIM : PW;
    localparam int SQW  = 2 * MW;
    localparam int LW   = SQW + 2;
    localparam int QB   = 2 * NB + 1;
    localparam int TW   = NB + 1;
    localparam int DLY  = QB + TW;
    localparam int PIPE = tun_pkg::FRONT_STAGES + DLY;
    localparam logic [TW-1:0] Q_FULL = TW'(1) << (NB - 1);
    localparam logic [NB-1:0] Q_LIM  = {1'b0, {(NB - 1){1'b1}}};
    localparam logic [NB-1:0] Q_MIN  = {1'b1, {(NB - 1){1'b0}}};

    logic                 adv;
    logic signed [CB-1:0] pt [9];
    logic [SQW-1:0]       sq [tun_pkg::LANES];
    logic                 neg [tun_pkg::LANES];
    logic [LW-1:0]        len2;
    logic [QB-1:0]        quo [tun_pkg::LANES];
    logic [TW-1:0]        root [tun_pkg::LANES];
    logic [3:0]           sb_reg [DLY];
    logic [PIPE-1:0]      vld_reg;
    logic                 ov_reg;
    logic [NB-1:0]        norm_reg [tun_pkg::LANES];
    logic                 deg_reg;
    logic [NB-1:0]        norm_next [tun_pkg::LANES];

    // global advance: output register empty or being read
    assign adv           = !ov_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // unpack corners
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            pt[i] = s_axis_tdata[i*CB +: CB];
        end
    end

    tun_front #(
        .CB  (CB),
        .SEW (SEW),
        .PW  (PW),
        .MW  (MW),
        .LW  (LW)
    ) u_front (
        .clk  (clk),
        .en   (adv),
        .pt   (pt),
        .sq   (sq),
        .len2 (len2),
        .neg  (neg)
    );

    // per component: divide by squared length, then root
    genvar g;
    generate
        for (g = 0; g < tun_pkg::LANES; g++)
        begin : g_lane
            tun_divide #(
                .SQW (SQW),
                .LW  (LW),
                .QB  (QB)
            ) u_div (
                .clk (clk),
                .en  (adv),
                .num (sq[g]),
                .den (len2),
                .quo (quo[g])
            );

            tun_isqrt #(
                .QB (QB),
                .TW (TW)
            ) u_sqrt (
                .clk  (clk),
                .en   (adv),
                .rad  (quo[g]),
                .root (root[g])
            );
        end
    endgenerate

    // signs and degenerate flag ride alongside divider and root
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= {len2 == '0, neg[2], neg[1], neg[0]};
            for (int i = 1; i < DLY; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    // round half up on the doubled root, clip, apply sign
    always_comb
    begin
        logic [TW:0]   rp;
        logic [TW-1:0] qw;
        logic [NB-1:0] qc;
        for (int i = 0; i < tun_pkg::LANES; i++)
        begin
            rp = (TW + 1)'(root[i]) + (TW + 1)'(1);
            qw = rp[TW:1];
            qc = (qw >= Q_FULL) ? Q_LIM : NB'(qw);
            if (sb_reg[DLY-1][3])
            begin
                norm_next[i] = '0;
            end
            else
            begin
                norm_next[i] = sb_reg[DLY-1][i] ? -qc : qc;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE-2:0], s_axis_tvalid};
            ov_reg  <= vld_reg[PIPE-1];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            norm_reg <= norm_next;
            deg_reg  <= sb_reg[DLY-1][3];
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = OW'({norm_reg[2], norm_reg[1], norm_reg[0]});
    assign m_axis_tuser  = deg_reg;

    // degenerate word carries an all-zero normal
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate word with nonzero normal");

    // magnitude clip never lets the most negative code out
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> norm_reg[0] != Q_MIN && norm_reg[1] != Q_MIN
                          && norm_reg[2] != Q_MIN)
        else $error("normal component outside clip range");

    // an accepted word enters the first pipeline stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted word lost at pipeline entry");

endmodule

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB       = 16;
    localparam int NB       = 16;
    localparam int IN_W     = ((9*CB+7)/8)*8;
    localparam int OUT_W    = ((3*NB+7)/8)*8;
    localparam int WDOG_MAX = 4000;
    localparam int DRAIN    = 80;

    typedef struct packed {
        logic [NB-1:0] nx;
        logic [NB-1:0] ny;
        logic [NB-1:0] nz;
        logic          degen;
    } normal_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    int err_count = 0;

    always #10 clk = ~clk;

    triangle_unit_normal_top #(.COORD_BITS(CB), .NORMAL_BITS(NB)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // rounded Q1.15 magnitude: largest q with (2q-1)^2 * len2 <= 4 * m^2 * 2^30
    function automatic longint unsigned unit_mag(longint unsigned m, longint unsigned len2);
        logic [127:0]    rhs;
        logic [127:0]    lhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        rhs = 128'(m * m) << (2*NB);
        lo = 0;
        hi = 64'd1 << (NB-1);
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2*mid - 1;
            lhs = 128'(t * t) * 128'(len2);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (lo > (64'd1 << (NB-1)) - 1)
            lo = (64'd1 << (NB-1)) - 1;
        return lo;
    endfunction

    function automatic normal_t face_normal(logic [IN_W-1:0] d);
        longint          p[9];
        longint          e[6];
        longint          n[3];
        longint unsigned mag[3];
        longint unsigned len2;
        longint unsigned mx;
        longint unsigned q;
        int              k;
        normal_t         r;
        for (int i = 0; i < 9; i++)
            p[i] = longint'($signed(d[CB*i +: CB]));
        for (int i = 0; i < 3; i++)
        begin
            e[i]   = p[6+i] - p[3+i];
            e[3+i] = p[i] - p[3+i];
        end
        n[0] = e[1]*e[5] - e[2]*e[4];
        n[1] = e[2]*e[3] - e[0]*e[5];
        n[2] = e[0]*e[4] - e[1]*e[3];
        // wide cross product: common right shift of the magnitudes
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);
            if (mag[i] > mx)
                mx = mag[i];
        end
        k = 0;
        while ((mx >> k) >= (64'd1 << 31))
            k++;
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mag[i] >> k;
            len2 += mag[i] * mag[i];
        end
        r = '0;
        if (len2 == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        q = unit_mag(mag[0], len2);
        r.nx = (n[0] < 0) ? NB'(-q) : NB'(q);
        q = unit_mag(mag[1], len2);
        r.ny = (n[1] < 0) ? NB'(-q) : NB'(q);
        q = unit_mag(mag[2], len2);
        r.nz = (n[2] < 0) ? NB'(-q) : NB'(q);
        return r;
    endfunction

    class normal_scoreboard;
        normal_t pending[$];

        function void note_input(logic [IN_W-1:0] d);
            pending = {pending, face_normal(d)};
        endfunction

        task check_result(logic [OUT_W-1:0] d, logic u);
            normal_t want;
            if (pending.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            want = pending.pop_front();
            if (d[0 +: NB] != want.nx)
                report($sformatf("norm_x %0d want %0d", $signed(d[0 +: NB]), $signed(want.nx)));
            if (d[NB +: NB] != want.ny)
                report($sformatf("norm_y %0d want %0d", $signed(d[NB +: NB]), $signed(want.ny)));
            if (d[2*NB +: NB] != want.nz)
                report($sformatf("norm_z %0d want %0d", $signed(d[2*NB +: NB]),
                                 $signed(want.nz)));
            if (u != want.degen)
                report($sformatf("degenerate %0b want %0b", u, want.degen));
        endtask
    endclass

    normal_scoreboard sb = new();

    // monitor both channels and the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [IN_W-1:0] pack_tri(logic [CB-1:0] c[9]);
        logic [IN_W-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++)
            d[CB*i +: CB] = c[i];
        return d;
    endfunction

    task automatic send_word(input logic [IN_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_tri(input int a0, a1, a2, b0, b1, b2, c0, c1, c2);
        logic [CB-1:0] c[9];
        c = '{CB'(a0), CB'(a1), CB'(a2), CB'(b0), CB'(b1), CB'(b2), CB'(c0), CB'(c1), CB'(c2)};
        send_word(pack_tri(c));
    endtask

    // random triangle: full range, clustered, collinear or extreme corners
    task automatic send_random;
        logic [CB-1:0] c[9];
        int            kind;
        int            base;
        int            s;
        kind = $urandom_range(99);
        for (int i = 0; i < 9; i++)
            c[i] = CB'($urandom);
        if (kind < 35)
        begin
            for (int i = 0; i < 3; i++)
            begin
                base = $signed(c[3+i]);
                s = 1 << $urandom_range(12);
                c[i]   = CB'(base + $urandom_range(2*s) - s);
                c[6+i] = CB'(base + $urandom_range(2*s) - s);
            end
        end
        else if (kind < 45)
        begin
            // collinear or repeated corners
            s = $urandom_range(4) - 2;
            for (int i = 0; i < 3; i++)
            begin
                c[i] = CB'($signed(c[3+i]) + $urandom_range(200) - 100);
                c[6+i] = CB'($signed(c[3+i]) + s * ($signed(c[i]) - $signed(c[3+i])));
            end
        end
        else if (kind < 55)
        begin
            for (int i = 0; i < 9; i++)
                c[i] = $urandom_range(1) ? 16'h8000 : 16'h7fff;
        end
        send_word(pack_tri(c));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_tri(256, 0, 0, 0, 0, 0, 0, 256, 0);
        send_tri(0, 256, 0, 0, 0, 0, 256, 0, 0);
        send_tri(0, 0, 256, 0, 0, 0, 0, 256, 0);
        send_tri(0, 256, 0, 0, 0, 0, 0, 0, 256);
        send_tri(256, 0, 0, 0, 0, 0, 0, 0, 256);
        send_tri(0, 0, 256, 0, 0, 0, 256, 0, 0);
        send_tri(1, 1, 0, 0, 0, 0, 1, 0, 1);
        send_tri(100, 100, 100, 100, 100, 100, 5, 7, 9);
        send_tri(1, 2, 3, 2, 4, 6, 3, 6, 9);
        send_tri(32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768, 32767);
        send_tri(32767, -32768, -32768, -32768, -32768, -32768, -32768, 32767, -32768);
        send_tri(32767, -32768, 32767, -32768, 32767, 32767, -32768, -32768, -32768);
        send_tri(-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768);
        send_tri(32767, 0, 0, -32768, 0, 0, 0, 32767, 0);
        send_tri(1, 0, 0, 0, 0, 0, 0, 1, 0);
        send_tri(-1, -1, -1, 0, 0, 0, 1, 1, 1);
        send_tri(3, 0, 0, 0, 0, 0, 0, 4, 12);
        send_tri(1, 0, 0, 0, 0, 0, 1, 1, 1);
        send_tri(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);

        // random phases with different idling
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                3: begin send_idle_pct = 10; recv_stall_pct = 10; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < 230; i++)
                send_random();
            if (ph == 1)
            begin
                // hold off until the pipeline has drained
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (err_count == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
